// File: design/assert_macros.svh
// Assertion helpers used by rc4_keyed_stream_cipher_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RC4_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define RC4_ASSERT_NEVER(label, clk, rst, expr) \
   `RC4_ASSERT(label, clk, rst, !(expr))
`else
`define RC4_ASSERT(label, clk, rst, prop)
`define RC4_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: design/rc4_pkg.sv
package rc4_pkg;

   localparam int PERM_DEPTH        = 256;
   localparam int PERM_AW           = $clog2(PERM_DEPTH);
   localparam int MAX_KEY_BYTES_DEF = 16;
   localparam int KEY_WORD_W        = 64;
   localparam int KEY_LEN_W         = 5;
   localparam int CSR_INDEX_W       = 2;

   localparam logic KIND_REKEY = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LEN  = 2'd2;

   localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KS_RD_I,
      ST_KS_RD_J,
      ST_KS_WR_I,
      ST_KS_WR_J,
      ST_DT_RD_I,
      ST_DT_RD_J,
      ST_DT_WR_I,
      ST_DT_WR_J,
      ST_DT_RD_T,
      ST_DT_OUT
   } state_type;

   typedef struct packed {
      logic               we;
      logic               re;
      logic [PERM_AW-1:0] addr;
      logic [7:0]         wdata;
   } mem_req_type;

   typedef struct packed {
      logic [KEY_WORD_W-1:0] key_low;
      logic [KEY_WORD_W-1:0] key_high;
      logic [KEY_LEN_W-1:0]  key_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       not_keyed;
   } res_type;

endpackage

// File: design/rc4_stream_if.sv
interface rc4_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface rc4_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       not_keyed;

   modport source (output valid, output out_byte, output not_keyed, input ready);
   modport sink (input valid, input out_byte, input not_keyed, output ready);
endinterface

// File: design/rc4_keyed_stream_cipher_unit.sv
// Rekey word: busy for 256 fill writes, then per schedule step reads S[i] and S[j] and writes both back.
// Data word: reads S[i], S[j], writes both, reads S[S[i]+S[j]], then holds the result until taken; the
// next word is accepted only after that. Unkeyed data word skips to the result. Single-port permutation RAM.
// Synchronous active-high reset clears indices, keyed flag, sequencer and output valid;
// key_length resets to 8, key words to 0; permutation RAM is not cleared.
`include "assert_macros.svh"

module rc4_keyed_stream_cipher_unit
   import rc4_pkg::*;
#(
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   rc4_req_if.sink                req_if,
   rc4_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [KEY_WORD_W-1:0]  csr_wdata
);

   cfg_type     cfg_ff;
   mem_req_type mem_req;
   logic [7:0]  mem_rdata;
   logic        eng_ready;
   logic        eng_res_valid;
   logic        eng_res_take;
   res_type     eng_res;
   logic        rsp_valid_ff;
   res_type     rsp_data_ff;
   logic        req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_low    <= '0;
         cfg_ff.key_high   <= '0;
         cfg_ff.key_length <= KEY_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_LOW:  cfg_ff.key_low    <= csr_wdata;
            CSR_KEY_HIGH: cfg_ff.key_high   <= csr_wdata;
            CSR_KEY_LEN:  cfg_ff.key_length <= csr_wdata[KEY_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   rc4_engine #(
      .MAX_KEY_BYTES(MAX_KEY_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_if.valid),
      .in_kind   (req_if.kind),
      .in_data   (req_if.data_byte),
      .in_ready  (eng_ready),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata),
      .res_valid (eng_res_valid),
      .res_take  (eng_res_take),
      .res       (eng_res)
   );

   rc4_perm_ram u_perm_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   assign req_if.ready = eng_ready;
   assign req_take     = req_if.valid && eng_ready;
   assign eng_res_take = eng_res_valid && (!rsp_valid_ff || rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_res_take) begin
         rsp_data_ff <= eng_res;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.out_byte  = rsp_data_ff.out_byte;
   assign rsp_if.not_keyed = rsp_data_ff.not_keyed;

   `RC4_ASSERT(a_rekey_busy, clock, reset, req_take && (req_if.kind == KIND_REKEY) |=> !eng_ready)
   `RC4_ASSERT(a_result_held, clock, reset, eng_res_valid && !eng_res_take |=> eng_res_valid)
   `RC4_ASSERT_NEVER(a_ready_while_result, clock, reset, eng_ready && eng_res_valid)

endmodule

// File: design/rc4_perm_ram.sv
module rc4_perm_ram
   import rc4_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rdata
);

   logic [7:0] mem [PERM_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end else if (mem_req.re) begin
         rdata_ff <= mem[mem_req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/rc4_engine.sv
module rc4_engine
   import rc4_pkg::*;
#(
   parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   input  logic        in_kind,
   input  logic [7:0]  in_data,
   output logic        in_ready,
   output mem_req_type mem_req,
   input  logic [7:0]  mem_rdata,
   output logic        res_valid,
   input  logic        res_take,
   output res_type     res
);

   localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam logic [PERM_AW-1:0] LAST_IDX = PERM_AW'(PERM_DEPTH - 1);

   state_type         state_ff, state_in;
   logic [PERM_AW-1:0] n_ff, n_in;
   logic [KIDX_W-1:0] k_ff, k_in;
   logic [7:0]        i_ff, i_in;
   logic [7:0]        j_ff, j_in;
   logic [7:0]        si_ff, si_in;
   logic [7:0]        sj_ff, sj_in;
   logic [7:0]        data_ff, data_in;
   logic              nk_ff, nk_in;
   logic              keyed_ff, keyed_in;

   logic [7:0]           key_bytes [16];
   logic [KEY_LEN_W-1:0] len_eff;
   logic [7:0]           key_byte;
   logic [7:0]           op_a, op_b, op_c, sum;

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         key_bytes[b]     = cfg.key_low[b*8 +: 8];
         key_bytes[b + 8] = cfg.key_high[b*8 +: 8];
      end
   end

   always_comb begin
      len_eff = cfg.key_length;
      if (len_eff == '0) begin
         len_eff = KEY_LEN_W'(1);
      end
      if (len_eff > KEY_LEN_W'(MAX_KEY_BYTES)) begin
         len_eff = KEY_LEN_W'(MAX_KEY_BYTES);
      end
   end

   assign key_byte = key_bytes[4'(k_ff)];

   // shared 8-bit index adder
   assign sum = op_a + op_b + op_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         keyed_ff <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         n_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         keyed_ff <= keyed_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         n_ff     <= n_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff   <= si_in;
      sj_ff   <= sj_in;
      data_ff <= data_in;
      nk_ff   <= nk_in;
   end

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      si_in     = si_ff;
      sj_in     = sj_ff;
      data_in   = data_ff;
      nk_in     = nk_ff;
      keyed_in  = keyed_ff;
      in_ready  = 1'b0;
      res_valid = 1'b0;
      op_a      = j_ff;
      op_b      = mem_rdata;
      op_c      = 8'd0;
      mem_req.we    = 1'b0;
      mem_req.re    = 1'b0;
      mem_req.addr  = n_ff;
      mem_req.wdata = 8'(n_ff);

      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               if (in_kind == KIND_REKEY) begin
                  n_in     = '0;
                  state_in = ST_INIT;
               end else begin
                  data_in = in_data;
                  nk_in   = !keyed_ff;
                  if (keyed_ff) begin
                     i_in     = i_ff + 8'd1;
                     state_in = ST_DT_RD_I;
                  end else begin
                     state_in = ST_DT_OUT;
                  end
               end
            end
         end
         ST_INIT: begin
            mem_req.we = 1'b1;
            n_in       = n_ff + 1'b1;
            if (n_ff == LAST_IDX) begin
               j_in     = '0;
               k_in     = '0;
               state_in = ST_KS_RD_I;
            end
         end
         ST_KS_RD_I: begin
            mem_req.re = 1'b1;
            state_in   = ST_KS_RD_J;
         end
         ST_KS_RD_J: begin
            op_c         = key_byte;
            si_in        = mem_rdata;
            j_in         = sum;
            mem_req.re   = 1'b1;
            mem_req.addr = sum;
            state_in     = ST_KS_WR_I;
         end
         ST_KS_WR_I: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = mem_rdata;
            state_in      = ST_KS_WR_J;
         end
         ST_KS_WR_J: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = j_ff;
            mem_req.wdata = si_ff;
            n_in          = n_ff + 1'b1;
            if (KEY_LEN_W'(k_ff) == len_eff - KEY_LEN_W'(1)) begin
               k_in = '0;
            end else begin
               k_in = k_ff + 1'b1;
            end
            if (n_ff == LAST_IDX) begin
               i_in     = '0;
               j_in     = '0;
               keyed_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_KS_RD_I;
            end
         end
         ST_DT_RD_I: begin
            mem_req.re   = 1'b1;
            mem_req.addr = i_ff;
            state_in     = ST_DT_RD_J;
         end
         ST_DT_RD_J: begin
            si_in        = mem_rdata;
            j_in         = sum;
            mem_req.re   = 1'b1;
            mem_req.addr = sum;
            state_in     = ST_DT_WR_I;
         end
         ST_DT_WR_I: begin
            sj_in         = mem_rdata;
            mem_req.we    = 1'b1;
            mem_req.addr  = i_ff;
            mem_req.wdata = mem_rdata;
            state_in      = ST_DT_WR_J;
         end
         ST_DT_WR_J: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = j_ff;
            mem_req.wdata = si_ff;
            state_in      = ST_DT_RD_T;
         end
         ST_DT_RD_T: begin
            op_a         = si_ff;
            op_b         = sj_ff;
            mem_req.re   = 1'b1;
            mem_req.addr = sum;
            state_in     = ST_DT_OUT;
         end
         ST_DT_OUT: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res.out_byte  = nk_ff ? data_ff : (data_ff ^ mem_rdata);
   assign res.not_keyed = nk_ff;

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
   import rc4_pkg::*;
();

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned DRAIN_CYCLES = 1400;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_WORDS   = 118;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [KEY_WORD_W-1:0]  csr_wdata;

   rc4_req_if req_bus ();
   rc4_rsp_if rsp_bus ();

   rc4_keyed_stream_cipher_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // cipher state as the block should hold it
   logic [KEY_WORD_W-1:0] key_lo;
   logic [KEY_WORD_W-1:0] key_hi;
   logic [KEY_LEN_W-1:0]  key_len;
   logic [7:0]            perm [PERM_DEPTH];
   logic [7:0]            idx_i;
   logic [7:0]            idx_j;
   logic                  keyed;

   res_type     pending_bytes [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          no_idle;
   bit          req_high;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      error_count++;
   endtask

   function void schedule_perm();
      int unsigned klen;
      int unsigned m;
      logic [7:0] j;
      logic [7:0] kb;
      logic [7:0] t;
      klen = (key_len == 0) ? 1 : ((key_len > MAX_KEY_BYTES_DEF) ? MAX_KEY_BYTES_DEF : key_len);
      for (int n = 0; n < PERM_DEPTH; n++)
         perm[n] = n[7:0];
      j = 8'd0;
      for (int n = 0; n < PERM_DEPTH; n++) begin
         m  = n % klen;
         kb = (m < 8) ? key_lo[m*8 +: 8] : key_hi[(m-8)*8 +: 8];
         j  = j + perm[n] + kb;
         t  = perm[n];
         perm[n] = perm[j];
         perm[j] = t;
      end
      idx_i = 8'd0;
      idx_j = 8'd0;
      keyed = 1'b1;
   endfunction

   function void cipher_word(input logic kind, input logic [7:0] data);
      res_type    r;
      logic [7:0] t;
      logic [7:0] sum;
      if (kind == KIND_REKEY) begin
         schedule_perm();
         return;
      end
      if (!keyed) begin
         r.out_byte  = data;
         r.not_keyed = 1'b1;
      end else begin
         idx_i = idx_i + 8'd1;
         idx_j = idx_j + perm[idx_i];
         t = perm[idx_i];
         perm[idx_i] = perm[idx_j];
         perm[idx_j] = t;
         sum = perm[idx_i] + perm[idx_j];
         r.out_byte  = data ^ perm[sum];
         r.not_keyed = 1'b0;
      end
      pending_bytes.push_back(r);
   endfunction

   task automatic send_word(input logic kind, input logic [7:0] data);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         req_high = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.data_byte <= data;
      req_high = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      cipher_word(kind, data);
   endtask

   task automatic drain_block(input int unsigned tail);
      if (req_high) begin
         req_bus.valid <= 1'b0;
         req_high = 1'b0;
         @(posedge clock);
      end
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [KEY_WORD_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_KEY_LOW:  key_lo  = value;
         CSR_KEY_HIGH: key_hi  = value;
         CSR_KEY_LEN:  key_len = value[KEY_LEN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_key(input logic [KEY_WORD_W-1:0] lo, input logic [KEY_WORD_W-1:0] hi,
                          input logic [KEY_WORD_W-1:0] len_word);
      drain_block(DRAIN_CYCLES);
      write_csr(CSR_KEY_LOW, lo);
      write_csr(CSR_KEY_HIGH, hi);
      write_csr(CSR_KEY_LEN, len_word);
   endtask

   // words before any rekey pass through flagged
   task automatic test_unkeyed_passthrough();
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_DATA, 8'hff);
      send_word(KIND_DATA, 8'h5a);
      send_word(KIND_DATA, 8'(($urandom)));
   endtask

   task automatic test_default_key();
      send_word(KIND_REKEY, 8'hff);
      send_word(KIND_DATA, 8'h00);
      send_word(KIND_DATA, 8'hff);
      send_word(KIND_DATA, 8'ha5);
   endtask

   // includes zero length and a length past the key store
   task automatic test_key_lengths();
      logic [4:0] lens [4];
      lens = '{5'd1, 5'd16, 5'd0, 5'd31};
      foreach (lens[k]) begin
         set_key(64'hfedc_ba98_7654_3210, 64'h0f1e_2d3c_4b5a_6978,
                 {{(KEY_WORD_W-KEY_LEN_W){1'b1}}, lens[k]});
         if (k == 1)
            write_csr(CSR_UNUSED, 64'hffff_ffff_ffff_ffff);
         send_word(KIND_REKEY, 8'h00);
         send_word(KIND_DATA, 8'(($urandom)));
      end
   endtask

   task automatic test_rekey_midstream();
      set_key(64'h0, 64'hffff_ffff_ffff_ffff, 64'd12);
      send_word(KIND_DATA, 8'h3c);
      send_word(KIND_REKEY, 8'(($urandom)));
      send_word(KIND_DATA, 8'hc3);
      send_word(KIND_REKEY, 8'h00);
      send_word(KIND_REKEY, 8'hff);
      send_word(KIND_DATA, 8'h81);
   endtask

   task automatic test_random_traffic();
      logic [KEY_WORD_W-1:0] lo;
      logic [KEY_WORD_W-1:0] hi;
      logic [KEY_WORD_W-1:0] len_word;
      int unsigned pick;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         lo = {$urandom, $urandom};
         hi = {$urandom, $urandom};
         if (p == 1) begin
            lo = '0;
            hi = '1;
         end
         len_word = {$urandom, $urandom};
         pick = $urandom_range(0, 9);
         case (pick)
            0: len_word[KEY_LEN_W-1:0] = 5'd0;
            1: len_word[KEY_LEN_W-1:0] = 5'd1;
            2: len_word[KEY_LEN_W-1:0] = 5'd16;
            3: len_word[KEY_LEN_W-1:0] = 5'($urandom_range(17, 31));
            default: len_word[KEY_LEN_W-1:0] = 5'($urandom_range(1, 16));
         endcase
         set_key(lo, hi, len_word);
         if (p == 3)
            write_csr(CSR_UNUSED, {$urandom, $urandom});
         no_idle = (p % 3 == 2);
         send_word(KIND_REKEY, 8'(($urandom)));
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 59) == 0)
               drain_block(0);
            send_word(($urandom_range(0, 99) < 3) ? KIND_REKEY : KIND_DATA,
                      8'(($urandom)));
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         int unsigned stall;
         res_type     want;
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (reset || rsp_bus.valid !== 1'b1);
         if (pending_bytes.size() == 0) begin
            report_mismatch("unexpected word, out_byte", rsp_bus.out_byte, 8'h00);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_bus.out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_bus.out_byte, want.out_byte);
            if (rsp_bus.not_keyed !== want.not_keyed)
               report_mismatch("not_keyed", 8'(rsp_bus.not_keyed), 8'(want.not_keyed));
         end
      end
   end

   initial begin
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.kind      <= KIND_DATA;
      req_bus.data_byte <= 8'h00;
      csr_we            <= 1'b0;
      csr_index         <= CSR_KEY_LOW;
      csr_wdata         <= '0;
      req_high    = 1'b0;
      no_idle     = 1'b0;
      key_lo  = '0;
      key_hi  = '0;
      key_len = KEY_LEN_RESET;
      idx_i   = 8'd0;
      idx_j   = 8'd0;
      keyed   = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unkeyed_passthrough();
      test_default_key();
      test_key_lengths();
      test_rekey_midstream();
      test_random_traffic();
      drain_block(DRAIN_CYCLES);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/rc4_pkg.sv
design/rc4_stream_if.sv
design/rc4_perm_ram.sv
design/rc4_engine.sv
design/rc4_keyed_stream_cipher_unit.sv
test/tb_top.sv
